// ===== hw/rtl/wsurl_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wsurl_pkg: shared types and constants for the ws/wss URL parser
// Parse phases, record layout, status codes, error flag positions.
// -----------------------------------------------------------------------------
package wsurl_pkg;

   // parse phase; scheme positions first so range tests work on the encoding
   typedef enum logic [3:0] {
      PH_S0     = 4'd0,
      PH_S1     = 4'd1,
      PH_S2     = 4'd2,
      PH_S3     = 4'd3,
      PH_S4     = 4'd4,
      PH_S5     = 4'd5,
      PH_AUTH0  = 4'd6,
      PH_HOST   = 4'd7,
      PH_PORT   = 4'd8,
      PH_V6     = 4'd9,
      PH_V6END  = 4'd10,
      PH_JUNK   = 4'd11,
      PH_PATH   = 4'd12,
      PH_SINK   = 4'd13
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HOST = 2'd0,
      KIND_PATH = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   localparam logic [3:0] STS_OK          = 4'd0;
   localparam logic [3:0] STS_SCHEME      = 4'd1;
   localparam logic [3:0] STS_NO_HOST     = 4'd2;
   localparam logic [3:0] STS_FRAGMENT    = 4'd3;
   localparam logic [3:0] STS_BAD_IPV6    = 4'd4;
   localparam logic [3:0] STS_BAD_HOST    = 4'd5;
   localparam logic [3:0] STS_UNBRACKETED = 4'd6;
   localparam logic [3:0] STS_WHITESPACE  = 4'd7;
   localparam logic [3:0] STS_BAD_PORT    = 4'd8;

   // error flag bit positions, in resolution order
   localparam int F_SCHEME  = 0;
   localparam int F_AUTH    = 1;
   localparam int F_EFRAG   = 2;
   localparam int F_V6      = 3;
   localparam int F_SUFFIX  = 4;
   localparam int F_COLON2  = 5;
   localparam int F_HEMPTY  = 6;
   localparam int F_WSPACE  = 7;
   localparam int F_PCHAR   = 8;
   localparam int F_PRANGE  = 9;
   localparam int F_PFRAG   = 10;
   localparam int NUM_FLAGS = 11;

   localparam logic [15:0] PORT_MAX = 16'd65535;
   localparam logic [16:0] PORT_SAT = 17'd65536;
   localparam logic [15:0] PORT_WSS = 16'd443;
   localparam logic [15:0] PORT_WS  = 16'd80;

   localparam int MAX_RECS   = 3;
   localparam int FIFO_DEPTH = 4;  // power of two, at least MAX_RECS + 1

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] port;
      logic        secure;
      logic [3:0]  status;
      logic        last;
   } rec_type;

   typedef struct packed {
      logic [1:0]                 count;
      rec_type [MAX_RECS-1:0]     recs;
   } step_type;

   typedef struct packed {
      phase_type              phase;
      logic                   secure_flag;
      logic [1:0]             colon_count;
      logic                   authority_len_nonzero;
      logic                   host_len_nonzero;
      logic                   authority_ends_colon;
      logic [16:0]            port_value;
      logic                   port_digit_seen;
      logic [NUM_FLAGS-1:0]   error_flags;
   } state_type;

   // all fields zero, phase = first scheme character
   localparam state_type STATE_RESET = '0;

endpackage

// ===== hw/rtl/wsurl_parser.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wsurl_parser: per-character parse state and record generation
// Holds the URL parse state; for each accepted character produces up to
// three output records in one pass.
// -----------------------------------------------------------------------------
module wsurl_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           ch,
   input  logic                 final_char,
   output wsurl_pkg::step_type  step
);

   wsurl_pkg::state_type state_ff, state_in;
   wsurl_pkg::state_type parsed;   // state after this character, before the done reset
   logic                 is_term;

   function automatic wsurl_pkg::rec_type mk_rec(wsurl_pkg::kind_type k, logic [7:0] b);
      wsurl_pkg::rec_type r;
      r           = '0;
      r.kind      = k;
      r.data_byte = b;
      return r;
   endfunction

   function automatic logic [wsurl_pkg::NUM_FLAGS-1:0] close_auth(wsurl_pkg::state_type s);
      logic [wsurl_pkg::NUM_FLAGS-1:0] f;
      f = s.error_flags;
      if (!s.authority_len_nonzero) f[wsurl_pkg::F_AUTH] = 1'b1;
      if (s.phase == wsurl_pkg::PH_V6) f[wsurl_pkg::F_V6] = 1'b1;
      if (s.authority_len_nonzero && !s.host_len_nonzero) f[wsurl_pkg::F_HEMPTY] = 1'b1;
      if (s.authority_ends_colon) f[wsurl_pkg::F_PCHAR] = 1'b1;
      if (s.port_digit_seen &&
          (s.port_value == 17'd0 || s.port_value > {1'b0, wsurl_pkg::PORT_MAX}))
         f[wsurl_pkg::F_PRANGE] = 1'b1;
      return f;
   endfunction

   function automatic logic [3:0] resolve(logic [wsurl_pkg::NUM_FLAGS-1:0] f);
      logic [3:0] st;
      if (f[wsurl_pkg::F_SCHEME])      st = wsurl_pkg::STS_SCHEME;
      else if (f[wsurl_pkg::F_AUTH])   st = wsurl_pkg::STS_NO_HOST;
      else if (f[wsurl_pkg::F_EFRAG])  st = wsurl_pkg::STS_FRAGMENT;
      else if (f[wsurl_pkg::F_V6])     st = wsurl_pkg::STS_BAD_IPV6;
      else if (f[wsurl_pkg::F_SUFFIX]) st = wsurl_pkg::STS_BAD_HOST;
      else if (f[wsurl_pkg::F_COLON2]) st = wsurl_pkg::STS_UNBRACKETED;
      else if (f[wsurl_pkg::F_HEMPTY]) st = wsurl_pkg::STS_NO_HOST;
      else if (f[wsurl_pkg::F_WSPACE]) st = wsurl_pkg::STS_WHITESPACE;
      else if (f[wsurl_pkg::F_PCHAR] || f[wsurl_pkg::F_PRANGE])
                                       st = wsurl_pkg::STS_BAD_PORT;
      else if (f[wsurl_pkg::F_PFRAG])  st = wsurl_pkg::STS_FRAGMENT;
      else                             st = wsurl_pkg::STS_OK;
      return st;
   endfunction

   assign is_term = (ch == "/") || (ch == "?") || (ch == "#");

   // next state
   always_comb begin
      wsurl_pkg::state_type s;
      logic                 do_host;
      logic [19:0]          acc;

      s       = state_ff;
      do_host = 1'b0;
      acc     = '0;

      if (s.phase <= wsurl_pkg::PH_S5) begin
         // scheme matcher
         case (s.phase)
            wsurl_pkg::PH_S0: begin
               s.phase = (ch == "w") ? wsurl_pkg::PH_S1 : wsurl_pkg::PH_SINK;
            end
            wsurl_pkg::PH_S1: begin
               s.phase = (ch == "s") ? wsurl_pkg::PH_S2 : wsurl_pkg::PH_SINK;
            end
            wsurl_pkg::PH_S2: begin
               if (ch == "s") begin
                  s.secure_flag = 1'b1;
                  s.phase       = wsurl_pkg::PH_S3;
               end else if (ch == ":") begin
                  s.phase = wsurl_pkg::PH_S4;
               end else begin
                  s.phase = wsurl_pkg::PH_SINK;
               end
            end
            wsurl_pkg::PH_S3: begin
               s.phase = (ch == ":") ? wsurl_pkg::PH_S4 : wsurl_pkg::PH_SINK;
            end
            wsurl_pkg::PH_S4: begin
               s.phase = (ch == "/") ? wsurl_pkg::PH_S5 : wsurl_pkg::PH_SINK;
            end
            default: begin
               s.phase = (ch == "/") ? wsurl_pkg::PH_AUTH0 : wsurl_pkg::PH_SINK;
            end
         endcase
         if (s.phase == wsurl_pkg::PH_SINK) s.error_flags[wsurl_pkg::F_SCHEME] = 1'b1;
      end else if (s.phase <= wsurl_pkg::PH_JUNK) begin
         if (is_term) begin
            // authority ends, path begins
            if (ch == "#") s.error_flags[wsurl_pkg::F_EFRAG] = 1'b1;
            s.error_flags = close_auth(s);
            s.phase       = wsurl_pkg::PH_PATH;
         end else begin
            s.authority_len_nonzero = 1'b1;
            s.authority_ends_colon  = 1'b0;
            if (ch == "@") s.error_flags[wsurl_pkg::F_AUTH] = 1'b1;
            case (s.phase)
               wsurl_pkg::PH_AUTH0: begin
                  if (ch == "[") begin
                     s.phase = wsurl_pkg::PH_V6;
                  end else begin
                     s.phase = wsurl_pkg::PH_HOST;
                     do_host = 1'b1;
                  end
               end
               wsurl_pkg::PH_HOST: begin
                  do_host = 1'b1;
               end
               wsurl_pkg::PH_PORT: begin
                  if (ch inside {["0":"9"]}) begin
                     s.port_digit_seen = 1'b1;
                     acc = (20'(s.port_value) << 3) + (20'(s.port_value) << 1)
                           + 20'(ch[3:0]);
                     s.port_value = (acc > 20'(wsurl_pkg::PORT_SAT)) ?
                                    wsurl_pkg::PORT_SAT : acc[16:0];
                  end else if (ch == ":" && s.colon_count != 2'd0) begin
                     s.colon_count = 2'd2;
                     s.error_flags[wsurl_pkg::F_COLON2] = 1'b1;
                  end else begin
                     s.error_flags[wsurl_pkg::F_PCHAR] = 1'b1;
                  end
               end
               wsurl_pkg::PH_V6: begin
                  if (ch == "]") begin
                     if (!s.host_len_nonzero) s.error_flags[wsurl_pkg::F_V6] = 1'b1;
                     s.phase = wsurl_pkg::PH_V6END;
                  end else begin
                     s.host_len_nonzero = 1'b1;
                     if (ch inside {" ", 8'h09, 8'h0d, 8'h0a})
                        s.error_flags[wsurl_pkg::F_WSPACE] = 1'b1;
                  end
               end
               wsurl_pkg::PH_V6END: begin
                  if (ch == ":") begin
                     s.authority_ends_colon = 1'b1;
                     s.phase                = wsurl_pkg::PH_PORT;
                  end else begin
                     s.error_flags[wsurl_pkg::F_SUFFIX] = 1'b1;
                     s.phase                            = wsurl_pkg::PH_JUNK;
                  end
               end
               default: begin
               end
            endcase
            // unbracketed host byte, or the colon opening its port
            if (do_host) begin
               if (ch == ":") begin
                  s.colon_count          = 2'd1;
                  s.authority_ends_colon = 1'b1;
                  s.phase                = wsurl_pkg::PH_PORT;
               end else begin
                  s.host_len_nonzero = 1'b1;
                  if (ch inside {" ", 8'h09, 8'h0d, 8'h0a})
                     s.error_flags[wsurl_pkg::F_WSPACE] = 1'b1;
               end
            end
         end
      end else if (s.phase == wsurl_pkg::PH_PATH) begin
         if (ch == "#") s.error_flags[wsurl_pkg::F_PFRAG] = 1'b1;
      end

      if (final_char) begin
         if (s.phase <= wsurl_pkg::PH_S5) begin
            s.error_flags[wsurl_pkg::F_SCHEME] = 1'b1;
         end else if (s.phase <= wsurl_pkg::PH_JUNK) begin
            s.error_flags = close_auth(s);
         end
      end

      parsed   = s;
      state_in = final_char ? wsurl_pkg::STATE_RESET : s;
   end

   // records for this character
   always_comb begin
      wsurl_pkg::step_type o;
      wsurl_pkg::rec_type  done;
      logic [1:0]          n;
      logic                host_out;
      logic [3:0]          st;

      o        = '0;
      done     = '0;
      n        = 2'd0;
      host_out = 1'b0;
      st       = resolve(parsed.error_flags);

      if (state_ff.phase inside {[wsurl_pkg::PH_AUTH0:wsurl_pkg::PH_JUNK]}) begin
         if (is_term) begin
            // leading '?' gets a '/' in front
            if (ch == "?") begin
               o.recs[n] = mk_rec(wsurl_pkg::KIND_PATH, "/");
               n         = n + 2'd1;
            end
            o.recs[n] = mk_rec(wsurl_pkg::KIND_PATH, ch);
            n         = n + 2'd1;
         end else begin
            case (state_ff.phase)
               wsurl_pkg::PH_AUTH0: host_out = (ch != "[") && (ch != ":");
               wsurl_pkg::PH_HOST:  host_out = (ch != ":");
               wsurl_pkg::PH_V6:    host_out = (ch != "]");
               default:             host_out = 1'b0;
            endcase
            if (host_out) begin
               o.recs[n] = mk_rec(wsurl_pkg::KIND_HOST, ch);
               n         = n + 2'd1;
            end
         end
      end else if (state_ff.phase == wsurl_pkg::PH_PATH) begin
         o.recs[n] = mk_rec(wsurl_pkg::KIND_PATH, ch);
         n         = n + 2'd1;
      end

      if (final_char) begin
         // no path given: default '/'
         if (parsed.phase inside {[wsurl_pkg::PH_AUTH0:wsurl_pkg::PH_JUNK]}) begin
            o.recs[n] = mk_rec(wsurl_pkg::KIND_PATH, "/");
            n         = n + 2'd1;
         end
         done.kind   = wsurl_pkg::KIND_DONE;
         if (st != wsurl_pkg::STS_OK)
            done.port = 16'd0;
         else if (parsed.port_digit_seen)
            done.port = parsed.port_value[15:0];
         else
            done.port = parsed.secure_flag ? wsurl_pkg::PORT_WSS : wsurl_pkg::PORT_WS;
         done.secure = parsed.secure_flag;
         done.status = st;
         done.last   = 1'b1;
         o.recs[n]   = done;
         n           = n + 2'd1;
      end

      o.count = n;
      step    = o;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsurl_pkg::STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/wsurl_fifo.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wsurl_fifo: result record queue
// Takes up to three records per cycle, hands out one per beat.
// -----------------------------------------------------------------------------
module wsurl_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  wsurl_pkg::step_type  push,
   output logic                 room,
   output logic                 head_valid,
   output wsurl_pkg::rec_type   head,
   input  logic                 pop
);

   localparam int DEPTH = wsurl_pkg::FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   wsurl_pkg::rec_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [1:0]          push_n;
   logic                pop_fire;

   assign push_n     = push_valid ? push.count : 2'd0;
   assign pop_fire   = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   // room for a worst-case item
   assign room       = (count_ff <= CNT_W'(DEPTH - wsurl_pkg::MAX_RECS));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop_fire);
   assign count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop_fire);

   always_ff @(posedge clock) begin
      if (push_valid) begin
         for (int k = 0; k < wsurl_pkg::MAX_RECS; k++) begin
            if (k < int'(push.count)) begin
               mem_ff[wr_ptr_ff + PTR_W'(k)] <= push.recs[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/websocket_url_parser_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// websocket_url_parser_top: streaming ws:// / wss:// URL parser
// Splits a URL, one character per beat, into host bytes, path bytes and a
// closing done record carrying port, secure flag and status.
// -----------------------------------------------------------------------------
// Usage:
//   req_*  : one URL character per beat; req_tlast marks the last character.
//   rsp_*  : one record per beat; rsp_tuser is the record kind (host byte,
//            path byte, done); rsp_tlast is set on the done record.
//   A character gives zero to three records. Records land in a four-entry
//   queue, which is registered, and show on rsp_* once earlier records are gone.
//   Throughput: one character per cycle while the queue has room for three
//   records; the rsp side drains one record per cycle while rsp_tready is high,
//   so runs of characters that each give two or three records are paced by rsp.
//   Parse state lives in one register set, updated by a single pass of
//   compare / multiply-by-ten logic per character.
//   Reset: parse state returns to the first scheme character, queue empties.
//   req_tready is high right after reset.
//   Stall: when rsp_tready is low the queue holds its records; req_tready
//   drops once fewer than three free slots remain.
//   Host and path bytes already sent are void if the done status is not ok.
// -----------------------------------------------------------------------------
module websocket_url_parser_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // final_char

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [23:8] port, [24] secure,
                                    // [28:25] status, [31:29] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);

   logic                accept;
   logic                room;
   wsurl_pkg::step_type step;
   wsurl_pkg::rec_type  head;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   wsurl_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .ch         (req_tdata),
      .final_char (req_tlast),
      .step       (step)
   );

   wsurl_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push       (step),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head       (head),
      .pop        (rsp_tready)
   );

   assign rsp_tdata = {3'b000, head.status, head.secure, head.port, head.data_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// ===== tb/sv/websocket_url_parser_top_test.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// websocket_url_parser_top_test: self-checking bench for the ws/wss URL parser
// Streams whole URLs one character per beat, predicts every host, path and done
// record in a local parse model, and compares each record field by field.
// -----------------------------------------------------------------------------
module websocket_url_parser_top_test;

   // idling pattern that travels with each character
   typedef enum logic [1:0] {
      GAP_NONE,
      GAP_SEND,
      GAP_RECV,
      GAP_BOTH
   } gap_mode_type;

   typedef struct {
      logic [7:0]   ch;
      logic         last;
      logic         hold;   // wait for all records of earlier URLs first
      gap_mode_type gap;
   } url_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   url_char_type        feed_q[$];      // characters not yet offered
   logic [7:0]          url_buf[$];     // URL under construction
   wsurl_pkg::rec_type  url_records[$]; // records predicted, not yet seen
   url_char_type        next_char;
   int                  url_count = 0;
   int                  errors = 0;
   logic                drained = 1'b1; // no record pending, as of the last edge
   logic                hold_wait = 1'b0;
   gap_mode_type        cur_gap = GAP_NONE;

   logic [7:0]  blanks [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};

   // parse model state
   wsurl_pkg::phase_type pstate;
   logic                 is_wss;
   logic [1:0]           colons;
   logic                 auth_seen;
   logic                 host_seen;
   logic                 colon_open;     // authority so far ends in the port colon
   logic [16:0]          port_acc;
   logic                 digit_seen;
   logic [wsurl_pkg::NUM_FLAGS-1:0] faults;

   websocket_url_parser_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Parse model
   // ---------------------------------------------------------------------------
   task automatic clear_url();
      pstate     = wsurl_pkg::PH_S0;
      is_wss     = 1'b0;
      colons     = 2'd0;
      auth_seen  = 1'b0;
      host_seen  = 1'b0;
      colon_open = 1'b0;
      port_acc   = 17'd0;
      digit_seen = 1'b0;
      faults     = '0;
   endtask

   task automatic push_rec(wsurl_pkg::kind_type k, logic [7:0] b);
      wsurl_pkg::rec_type r;
      r = '0;
      r.kind = k;
      r.data_byte = b;
      url_records.push_back(r);
   endtask

   task automatic emit_host(logic [7:0] c);
      host_seen = 1'b1;
      if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A)
         faults[wsurl_pkg::F_WSPACE] = 1'b1;
      push_rec(wsurl_pkg::KIND_HOST, c);
   endtask

   // authority ends: on a path delimiter or on the final character
   task automatic close_auth();
      if (!auth_seen) faults[wsurl_pkg::F_AUTH] = 1'b1;
      if (pstate == wsurl_pkg::PH_V6) faults[wsurl_pkg::F_V6] = 1'b1;
      if (auth_seen && !host_seen) faults[wsurl_pkg::F_HEMPTY] = 1'b1;
      if (colon_open) faults[wsurl_pkg::F_PCHAR] = 1'b1;
      if (digit_seen && (port_acc == 17'd0 || port_acc > {1'b0, wsurl_pkg::PORT_MAX}))
         faults[wsurl_pkg::F_PRANGE] = 1'b1;
   endtask

   task automatic parse_char(logic [7:0] c, logic fin);
      wsurl_pkg::phase_type nxt;
      logic [3:0]           st;
      logic [15:0]          prt;
      int                   acc;
      wsurl_pkg::rec_type   done_rec;
      if (pstate <= wsurl_pkg::PH_S5) begin
         // scheme: "ws://" or "wss://", anything else sinks the URL
         nxt = wsurl_pkg::PH_SINK;
         case (pstate)
            wsurl_pkg::PH_S0: if (c == "w") nxt = wsurl_pkg::PH_S1;
            wsurl_pkg::PH_S1: if (c == "s") nxt = wsurl_pkg::PH_S2;
            wsurl_pkg::PH_S2: begin
               if (c == "s") begin
                  is_wss = 1'b1;
                  nxt = wsurl_pkg::PH_S3;
               end else if (c == ":") begin
                  nxt = wsurl_pkg::PH_S4;
               end
            end
            wsurl_pkg::PH_S3: if (c == ":") nxt = wsurl_pkg::PH_S4;
            wsurl_pkg::PH_S4: if (c == "/") nxt = wsurl_pkg::PH_S5;
            default: if (c == "/") nxt = wsurl_pkg::PH_AUTH0;
         endcase
         if (nxt == wsurl_pkg::PH_SINK) faults[wsurl_pkg::F_SCHEME] = 1'b1;
         pstate = nxt;
      end else if (pstate <= wsurl_pkg::PH_JUNK) begin
         if (c == "/" || c == "?" || c == "#") begin
            if (c == "#") faults[wsurl_pkg::F_EFRAG] = 1'b1;
            close_auth();
            if (c == "?") push_rec(wsurl_pkg::KIND_PATH, "/");
            push_rec(wsurl_pkg::KIND_PATH, c);
            pstate = wsurl_pkg::PH_PATH;
         end else begin
            auth_seen = 1'b1;
            colon_open = 1'b0;
            if (c == "@") faults[wsurl_pkg::F_AUTH] = 1'b1;
            if (pstate == wsurl_pkg::PH_AUTH0 && c == "[") begin
               pstate = wsurl_pkg::PH_V6;
            end else begin
               if (pstate == wsurl_pkg::PH_AUTH0) pstate = wsurl_pkg::PH_HOST;
               case (pstate)
                  wsurl_pkg::PH_HOST: begin
                     if (c == ":") begin
                        colons = 2'd1;
                        colon_open = 1'b1;
                        pstate = wsurl_pkg::PH_PORT;
                     end else begin
                        emit_host(c);
                     end
                  end
                  wsurl_pkg::PH_PORT: begin
                     if (c >= "0" && c <= "9") begin
                        digit_seen = 1'b1;
                        acc = port_acc * 10 + (c - "0");
                        port_acc = (acc > wsurl_pkg::PORT_SAT) ?
                                   wsurl_pkg::PORT_SAT : acc[16:0];
                     end else if (c == ":" && colons != 2'd0) begin
                        colons = 2'd2;
                        faults[wsurl_pkg::F_COLON2] = 1'b1;
                     end else begin
                        faults[wsurl_pkg::F_PCHAR] = 1'b1;
                     end
                  end
                  wsurl_pkg::PH_V6: begin
                     if (c == "]") begin
                        if (!host_seen) faults[wsurl_pkg::F_V6] = 1'b1;
                        pstate = wsurl_pkg::PH_V6END;
                     end else begin
                        emit_host(c);
                     end
                  end
                  wsurl_pkg::PH_V6END: begin
                     if (c == ":") begin
                        colon_open = 1'b1;
                        pstate = wsurl_pkg::PH_PORT;
                     end else begin
                        faults[wsurl_pkg::F_SUFFIX] = 1'b1;
                        pstate = wsurl_pkg::PH_JUNK;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end else if (pstate == wsurl_pkg::PH_PATH) begin
         if (c == "#") faults[wsurl_pkg::F_PFRAG] = 1'b1;
         push_rec(wsurl_pkg::KIND_PATH, c);
      end

      if (fin) begin
         if (pstate <= wsurl_pkg::PH_S5) begin
            faults[wsurl_pkg::F_SCHEME] = 1'b1;
         end else if (pstate <= wsurl_pkg::PH_JUNK) begin
            close_auth();
            push_rec(wsurl_pkg::KIND_PATH, "/");
         end
         // first fault in priority order decides the status
         if (faults[wsurl_pkg::F_SCHEME])      st = wsurl_pkg::STS_SCHEME;
         else if (faults[wsurl_pkg::F_AUTH])   st = wsurl_pkg::STS_NO_HOST;
         else if (faults[wsurl_pkg::F_EFRAG])  st = wsurl_pkg::STS_FRAGMENT;
         else if (faults[wsurl_pkg::F_V6])     st = wsurl_pkg::STS_BAD_IPV6;
         else if (faults[wsurl_pkg::F_SUFFIX]) st = wsurl_pkg::STS_BAD_HOST;
         else if (faults[wsurl_pkg::F_COLON2]) st = wsurl_pkg::STS_UNBRACKETED;
         else if (faults[wsurl_pkg::F_HEMPTY]) st = wsurl_pkg::STS_NO_HOST;
         else if (faults[wsurl_pkg::F_WSPACE]) st = wsurl_pkg::STS_WHITESPACE;
         else if (faults[wsurl_pkg::F_PCHAR] || faults[wsurl_pkg::F_PRANGE])
                                               st = wsurl_pkg::STS_BAD_PORT;
         else if (faults[wsurl_pkg::F_PFRAG])  st = wsurl_pkg::STS_FRAGMENT;
         else                                  st = wsurl_pkg::STS_OK;
         prt = digit_seen ? port_acc[15:0] :
               (is_wss ? wsurl_pkg::PORT_WSS : wsurl_pkg::PORT_WS);
         if (st != wsurl_pkg::STS_OK) prt = 16'd0;
         done_rec = '0;
         done_rec.kind = wsurl_pkg::KIND_DONE;
         done_rec.port = prt;
         done_rec.secure = is_wss;
         done_rec.status = st;
         done_rec.last = 1'b1;
         url_records.push_back(done_rec);
         clear_url();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Record check
   // ---------------------------------------------------------------------------
   function automatic logic field_bad(string name, int want, int got);
      if (want == got) return 1'b0;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b1;
   endfunction

   task automatic check_record();
      wsurl_pkg::rec_type want;
      logic               bad;
      if (url_records.size() == 0) begin
         $display("%0t ns: record with none expected, actual kind %0d tdata %h last %b",
                  $time, rsp_tuser, rsp_tdata, rsp_tlast);
         errors++;
         return;
      end
      want = url_records.pop_front();
      bad = field_bad("kind", want.kind, rsp_tuser);
      bad |= field_bad("data_byte", want.data_byte, rsp_tdata[7:0]);
      bad |= field_bad("port", want.port, rsp_tdata[23:8]);
      bad |= field_bad("secure", want.secure, rsp_tdata[24]);
      bad |= field_bad("status", want.status, rsp_tdata[28:25]);
      bad |= field_bad("tdata pad", 0, rsp_tdata[31:29]);
      bad |= field_bad("last", want.last, rsp_tlast);
      if (bad) errors++;
   endtask

   // ---------------------------------------------------------------------------
   // URL construction
   // ---------------------------------------------------------------------------
   task automatic put_byte(logic [7:0] b);
      url_buf.push_back(b);
   endtask

   task automatic put_text(string s);
      for (int k = 0; k < s.len(); k++) url_buf.push_back(s[k]);
   endtask

   function automatic logic [7:0] pick_from(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // mostly plain host characters, some whitespace, some raw bytes
   function automatic logic [7:0] host_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return blanks[$urandom_range(0, 3)];
      if (r < 15) return 8'($urandom_range(0, 255));
      return pick_from("abcxyz0189.-");
   endfunction

   // move the built URL to the feed; tlast on its final character
   task automatic flush_url(logic hold);
      url_char_type item;
      foreach (url_buf[i]) begin
         item.ch   = url_buf[i];
         item.last = (i == url_buf.size() - 1);
         item.hold = hold && (i == 0);
         // idling pattern rotates every 40 characters
         item.gap  = gap_mode_type'((feed_q.size() / 40) % 4);
         feed_q.push_back(item);
      end
      url_buf.delete();
      url_count++;
   endtask

   // random URL: mostly well formed, with broken pieces mixed in
   task automatic make_url();
      int    pick;
      int    n;
      int    k;
      string s;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // line noise
         n = $urandom_range(1, 4);
         repeat (n) put_byte(8'($urandom_range(0, 255)));
         return;
      end
      if (pick < 16) begin
         // scheme usually goes wrong after a random prefix; the tail is then ignored
         s = "wss://";
         n = $urandom_range(0, 5);
         for (k = 0; k < n; k++) put_byte(s[k]);
         put_byte(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 1) put_text("h/p");
         return;
      end
      if ($urandom_range(0, 1) == 1) put_text("wss://");
      else put_text("ws://");

      // authority: name, bracketed address, or user info
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         n = (pick < 4) ? 0 : $urandom_range(1, 3);
         repeat (n) put_byte(host_char());
      end else if (pick < 85) begin
         put_text("[");
         n = (pick < 64) ? 0 : $urandom_range(1, 3);
         repeat (n) put_byte(pick_from("0123456789abcdef:"));
         if ($urandom_range(0, 99) < 85) put_text("]");
         if ($urandom_range(0, 99) < 10) put_byte(host_char());
      end else begin
         put_text("u@h");
      end

      // port
      pick = $urandom_range(0, 99);
      if (pick >= 45) begin
         put_text(":");
         case ($urandom_range(0, 7))
            0: ;
            1: put_text("0");
            2: put_text("65535");
            3: put_text("65536");
            4: put_text("99999999");
            default: begin
               n = $urandom_range(1, 5);
               repeat (n) put_byte(pick_from("0123456789"));
            end
         endcase
         if (pick >= 92) put_text(":1");
         else if (pick >= 88) put_byte(host_char());
      end

      // path, query or fragment
      pick = $urandom_range(0, 99);
      if (pick >= 35) begin
         if (pick < 75) put_text("/");
         else if (pick < 92) put_text("?");
         else put_text("#");
         n = $urandom_range(0, 3);
         repeat (n) begin
            if ($urandom_range(0, 9) == 0) put_byte(8'($urandom_range(0, 255)));
            else put_byte(pick_from("az09/?#=&"));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver: offers characters from the feed, holds each beat until taken.
   // Gaps only go in between beats; a hold item first waits for the record
   // queue to drain (drained is registered, so hold_wait is set before drained counts).
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         hold_wait <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (feed_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (feed_q[0].hold && !(hold_wait && drained)) begin
            req_tvalid <= 1'b0;
            hold_wait <= 1'b1;
         end else if ((feed_q[0].gap == GAP_SEND && $urandom_range(0, 99) < 62) ||
                      (feed_q[0].gap == GAP_BOTH && $urandom_range(0, 99) < 13)) begin
            req_tvalid <= 1'b0;
         end else begin
            next_char = feed_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_char.ch;
            req_tlast <= next_char.last;
            cur_gap <= next_char.gap;
            hold_wait <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: predicts on each accepted character, checks each accepted record,
   // and stalls the record side per the current idling pattern.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         clear_url();
         rsp_tready <= 1'b0;
         drained <= 1'b1;
      end else begin
         if (req_tvalid && req_tready) parse_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_record();
         drained <= (url_records.size() == 0);
         rsp_tready <= !((cur_gap == GAP_RECV && $urandom_range(0, 99) < 62) ||
                         (cur_gap == GAP_BOTH && $urandom_range(0, 99) < 13));
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin
      int directed_len;

      // final character inside the authority: default '/' path, then done
      put_text("ws://a");
      flush_url(1'b0);
      // colon within the port of a bracketed host is a bad port byte
      put_text("wss://[1]:2:3");
      flush_url(1'b0);
      // final character on a leading '?': '/', '?', done
      put_text("ws://h?");
      flush_url(1'b0);
      // scheme mismatch; the byte after it is ignored
      put_text("x");
      put_byte(8'hFF);
      flush_url(1'b0);
      // zero byte as host, fragment in path voids the bytes sent
      put_text("ws://");
      put_byte(8'h00);
      put_text("/#");
      flush_url(1'b0);
      // largest legal port
      put_text("wss://h:65535");
      flush_url(1'b0);

      directed_len = feed_q.size();
      while (feed_q.size() < directed_len + 250) begin
         make_url();
         flush_url(url_count % 8 == 0);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sample away from the active edge: feed empty, beat taken, records in
      do @(negedge clock);
      while (feed_q.size() != 0 || req_tvalid || url_records.size() != 0);
      repeat (20) @(negedge clock);

      if (errors == 0 && url_records.size() == 0) begin
         $display("websocket_url_parser_top_test OK");
      end else begin
         $display("websocket_url_parser_top_test NOT OK");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("websocket_url_parser_top_test NOT OK");
      $finish;
   end

endmodule

// ===== websocket_url_parser_top.f =====
hw/rtl/wsurl_pkg.sv
hw/rtl/wsurl_parser.sv
hw/rtl/wsurl_fifo.sv
hw/rtl/websocket_url_parser_top.sv
tb/sv/websocket_url_parser_top_test.sv
